// ----- rtl/core/one_wire_master_timing_unit_assert.svh -----
// Assertion macros for the single-wire bus master timing unit.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef ONE_WIRE_MASTER_TIMING_UNIT_ASSERT_SVH
`define ONE_WIRE_MASTER_TIMING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset
`define OWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define OWM_ASSERT_IMP(lbl, ante, cons, msg) \
  `OWM_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies another in the following cycle
`define OWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OWM_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define OWM_ASSERT(lbl, prop, msg)
`define OWM_ASSERT_IMP(lbl, ante, cons, msg)
`define OWM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/owm_pkg.sv -----
// Shared types, codes and constants of the single-wire bus master timing unit.
// Used by owm_front, owm_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package owm_pkg;

  // Command carried by one tick item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_PRES    = 2'd1;
  localparam logic [1:0] STATUS_PRES_STUCK = 2'd2;
  localparam logic [1:0] STATUS_BUSY       = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_LOW_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LONG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL    = 3'd7;

  // Register reset values
  localparam logic [9:0] RST_RESET_LOW    = 10'd650;
  localparam logic [7:0] RST_RECOVERY     = 8'd15;
  localparam logic [7:0] RST_PRES_WAIT    = 8'd200;
  localparam logic [7:0] RST_PRES_LOW_MAX = 8'd240;
  localparam logic [7:0] RST_SLOT_LONG    = 8'd60;
  localparam logic [3:0] RST_SHORT_LOW    = 4'd2;
  localparam logic [5:0] RST_SAMPLE_DELAY = 6'd12;
  localparam logic [7:0] RST_READ_TAIL    = 8'd50;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified tick item
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] write_value;
    logic       line_in;
  } item_t;

  // Segment length in ticks: zero still lasts one tick
  function automatic logic [9:0] seg_len(input logic [9:0] v);
    seg_len = (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

// ----- rtl/core/owm_front.sv -----
// Front part: accepts tick items, classifies the action and queues them.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_front #(
  parameter int unsigned Depth = owm_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     action_i,
  input  logic [7:0]     write_value_i,
  input  logic           line_in_i,
  output logic           head_valid_o,
  output owm_pkg::item_t head_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  owm_pkg::item_t      store_q [Depth];
  owm_pkg::item_t      item;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push;

  // Classify the action into a command
  always_comb begin
    item.cmd         = owm_pkg::cmd_e'(action_i);
    item.write_value = write_value_i;
    item.line_in     = line_in_i;
  end

  assign in_stall_o   = (cnt_q == FullCnt);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = store_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ----- rtl/core/owm_back.sv -----
// Back part: bus timing sequencer, configuration registers and result register.
// Depends on owm_pkg; takes queued items from owm_front.
`timescale 1ns / 1ps

module owm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [owm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [owm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             head_valid_i,
  input  owm_pkg::item_t                   head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             drive_low_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic [7:0]                       read_result_o,
  output logic [1:0]                       status_o
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REC   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_HIGH   = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_WAIT   = 4'd8,
    PH_RD_TAIL   = 4'd9
  } phase_e;

  // Configuration registers
  logic [9:0] reset_low_q;
  logic [7:0] recovery_q, pres_wait_q, pres_low_max_q, slot_long_q, read_tail_q;
  logic [3:0] short_low_q;
  logic [5:0] sample_delay_q;

  // Sequencer state and result register
  phase_e     phase_q, phase_d;
  logic [9:0] timer_q, timer_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d;
  logic [1:0] outcome_q, outcome_d;
  logic [7:0] last_read_q, last_read_d;
  logic       out_valid_q, drive_q, drive_d, done_q, done_d;

  logic [9:0] short_len, long_len;
  logic       ended;
  logic [9:0] timer_dec;

  assign cfg_ready_o = 1'b1;

  // Take the next item when the result register is free or draining
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  assign short_len = owm_pkg::seg_len({6'd0, short_low_q});
  assign long_len  = owm_pkg::seg_len({2'd0, slot_long_q});

  // One tick of the bus sequencer
  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    outcome_d   = outcome_q;
    last_read_d = last_read_q;
    drive_d     = 1'b0;
    done_d      = 1'b0;

    // Launch a command when idle, flag it when busy
    if (phase_q == PH_IDLE) begin
      if (head_i.cmd != owm_pkg::CMD_TICK) begin
        outcome_d = owm_pkg::STATUS_OK;
        bit_d     = 3'd0;
        wait_d    = 8'd0;
        case (head_i.cmd)
          owm_pkg::CMD_RESET: begin
            phase_d = PH_RST_LOW;
            timer_d = owm_pkg::seg_len(reset_low_q);
          end
          owm_pkg::CMD_WRITE: begin
            shift_d = head_i.write_value;
            phase_d = PH_WR_LOW;
            timer_d = head_i.write_value[0] ? short_len : long_len;
          end
          default: begin
            shift_d = 8'd0;
            phase_d = PH_RD_LOW;
            timer_d = short_len;
          end
        endcase
      end
    end else if (head_i.cmd != owm_pkg::CMD_TICK) begin
      outcome_d = owm_pkg::STATUS_BUSY;
    end

    ended     = (timer_d <= 10'd1);
    timer_dec = ended ? 10'd0 : timer_d - 10'd1;

    // Run the tick in the current segment
    case (phase_d)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        drive_d = 1'b1;
        timer_d = timer_dec;
        if (ended) begin
          phase_d = PH_RST_REC;
          timer_d = owm_pkg::seg_len({2'd0, recovery_q});
        end
      end
      PH_RST_REC: begin
        timer_d = timer_dec;
        if (ended) begin
          phase_d = PH_PRES_WAIT;
          wait_d  = 8'd0;
        end
      end
      PH_PRES_WAIT: begin
        if (wait_d >= pres_wait_q) begin
          outcome_d = owm_pkg::STATUS_NO_PRES;
          phase_d   = PH_IDLE;
          timer_d   = 10'd0;
          done_d    = 1'b1;
        end else if (head_i.line_in) begin
          wait_d = wait_d + 8'd1;
        end else if (pres_low_max_q == 8'd0) begin
          // pulse limit of zero fails on the first low tick
          outcome_d = owm_pkg::STATUS_PRES_STUCK;
          phase_d   = PH_IDLE;
          timer_d   = 10'd0;
          done_d    = 1'b1;
          wait_d    = 8'd0;
        end else begin
          phase_d = PH_PRES_LOW;
          wait_d  = 8'd1;
        end
      end
      PH_PRES_LOW: begin
        if (wait_d >= pres_low_max_q) begin
          outcome_d = owm_pkg::STATUS_PRES_STUCK;
          phase_d   = PH_IDLE;
          timer_d   = 10'd0;
          done_d    = 1'b1;
        end else if (!head_i.line_in) begin
          wait_d = wait_d + 8'd1;
        end else begin
          outcome_d = owm_pkg::STATUS_OK;
          phase_d   = PH_IDLE;
          timer_d   = 10'd0;
          done_d    = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive_d = 1'b1;
        timer_d = timer_dec;
        if (ended) begin
          phase_d = PH_WR_HIGH;
          timer_d = shift_d[0] ? long_len : short_len;
        end
      end
      PH_WR_HIGH: begin
        timer_d = timer_dec;
        if (ended) begin
          shift_d = {1'b0, shift_d[7:1]};
          if (bit_d == 3'd7) begin
            outcome_d = owm_pkg::STATUS_OK;
            phase_d   = PH_IDLE;
            timer_d   = 10'd0;
            done_d    = 1'b1;
          end else begin
            bit_d   = bit_d + 3'd1;
            phase_d = PH_WR_LOW;
            timer_d = shift_d[0] ? short_len : long_len;
          end
        end
      end
      PH_RD_LOW: begin
        drive_d = 1'b1;
        timer_d = timer_dec;
        if (ended) begin
          phase_d = PH_RD_WAIT;
          timer_d = owm_pkg::seg_len({4'd0, sample_delay_q});
        end
      end
      PH_RD_WAIT: begin
        timer_d = timer_dec;
        if (ended) begin
          shift_d = {head_i.line_in, shift_d[7:1]};
          phase_d = PH_RD_TAIL;
          timer_d = owm_pkg::seg_len({2'd0, read_tail_q});
        end
      end
      PH_RD_TAIL: begin
        timer_d = timer_dec;
        if (ended) begin
          if (bit_d == 3'd7) begin
            last_read_d = shift_d;
            outcome_d   = owm_pkg::STATUS_OK;
            phase_d     = PH_IDLE;
            timer_d     = 10'd0;
            done_d      = 1'b1;
          end else begin
            bit_d   = bit_d + 3'd1;
            phase_d = PH_RD_LOW;
            timer_d = short_len;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Hold sequencer state and result register; advance on each popped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= 10'd0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      wait_q      <= 8'd0;
      outcome_q   <= owm_pkg::STATUS_OK;
      last_read_q <= 8'd0;
      drive_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        timer_q     <= timer_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        wait_q      <= wait_d;
        outcome_q   <= outcome_d;
        last_read_q <= last_read_d;
        drive_q     <= drive_d;
        done_q      <= done_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q    <= owm_pkg::RST_RESET_LOW;
      recovery_q     <= owm_pkg::RST_RECOVERY;
      pres_wait_q    <= owm_pkg::RST_PRES_WAIT;
      pres_low_max_q <= owm_pkg::RST_PRES_LOW_MAX;
      slot_long_q    <= owm_pkg::RST_SLOT_LONG;
      short_low_q    <= owm_pkg::RST_SHORT_LOW;
      sample_delay_q <= owm_pkg::RST_SAMPLE_DELAY;
      read_tail_q    <= owm_pkg::RST_READ_TAIL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        owm_pkg::REG_RESET_LOW:    reset_low_q    <= cfg_data_i;
        owm_pkg::REG_RECOVERY:     recovery_q     <= cfg_data_i[7:0];
        owm_pkg::REG_PRES_WAIT:    pres_wait_q    <= cfg_data_i[7:0];
        owm_pkg::REG_PRES_LOW_MAX: pres_low_max_q <= cfg_data_i[7:0];
        owm_pkg::REG_SLOT_LONG:    slot_long_q    <= cfg_data_i[7:0];
        owm_pkg::REG_SHORT_LOW:    short_low_q    <= cfg_data_i[3:0];
        owm_pkg::REG_SAMPLE_DELAY: sample_delay_q <= cfg_data_i[5:0];
        owm_pkg::REG_READ_TAIL:    read_tail_q    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_low_o   = drive_q;
  assign busy_res_o    = (phase_q != PH_IDLE);
  assign done_res_o    = done_q;
  assign read_result_o = last_read_q;
  assign status_o      = outcome_q;

endmodule

// ----- rtl/core/one_wire_master_timing_unit.sv -----
// Top level of the single-wire bus master timing unit.
// Instantiates owm_front and owm_back; depends on owm_pkg and the assertion header.
`timescale 1ns / 1ps

// Single-wire bus master driven by microsecond ticks. Each accepted item is one
// tick carrying the sampled line level and an action (tick only, bus reset with
// presence check, write byte, read byte); each tick yields exactly one result
// with the drive level, busy, done, the last read byte and a status. A command
// is started only while idle; one requested while busy is ignored and shows
// status 3 until the running command ends. One tick is taken every clock cycle
// unless the item queue is full or the result register is stalled: the
// sequencer steps one tick per cycle while not stalled. An accepted item waits
// in the item queue and is then stepped into the result register, from which
// it shows on the outputs. The item queue, QueueDepth entries deep, lets input
// and output stall independently. Timing registers are written through the
// configuration port, which is always ready, and should be changed only while
// idle.
module one_wire_master_timing_unit #(
  parameter int unsigned QueueDepth = owm_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [7:0]                     write_value_i,
  input  logic                           line_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           drive_low_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     read_result_o,
  output logic [1:0]                     status_o
);

  `include "one_wire_master_timing_unit_assert.svh"

  logic           head_valid;
  owm_pkg::item_t head;
  logic           pop;

  owm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .write_value_i (write_value_i),
    .line_in_i     (line_in_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  owm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_low_o   (drive_low_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .read_result_o (read_result_o),
    .status_o      (status_o)
  );

  // An accepted item is queued for the back part in the next cycle
  `OWM_ASSERT_NEXT(a_push_queued, in_valid_i && !in_stall_o, head_valid, "accepted item lost")

  // Every item taken by the back part shows up as a result
  `OWM_ASSERT_NEXT(a_pop_result, pop, out_valid_o, "popped item gave no result")

  // A finishing command is no longer busy
  `OWM_ASSERT_IMP(a_done_idle, out_valid_o && done_res_o, !busy_res_o, "done while busy")

  // A busy rejection is only visible while the running command continues
  `OWM_ASSERT_IMP(a_reject_busy, out_valid_o && (status_o == owm_pkg::STATUS_BUSY),
                  busy_res_o, "busy rejection shown while idle")

endmodule
